[rtl/tds_pkg.sv]
// ----------------------------------------------------------------------------
// Tridiagonal solver package
// Shared types, constants and fixed-point helpers for the solver blocks.
// ----------------------------------------------------------------------------
package tds_pkg;

  localparam int MAX_ROWS    = 64;
  localparam int VALUE_WIDTH = 32;
  localparam int FX_W        = 48;
  localparam int FRAC_BITS   = 24;
  localparam int PORT_SHIFT  = 8;
  localparam int ROW_W       = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CNT_W       = $clog2(MAX_ROWS + 1);

  typedef logic signed [VALUE_WIDTH-1:0] val_t;
  typedef logic signed [FX_W-1:0]        fx_t;
  typedef logic [ROW_W-1:0]              row_t;
  typedef logic [CNT_W-1:0]              cnt_t;

  localparam fx_t FX_MAX = {1'b0, {(FX_W-1){1'b1}}};
  localparam fx_t FX_MIN = {1'b1, {(FX_W-1){1'b0}}};
  localparam logic signed [63:0] WIDE_MAX = 64'(FX_MAX);
  localparam logic signed [63:0] WIDE_MIN = 64'(FX_MIN);
  localparam logic signed [63:0] VAL_MAX  = (64'sd1 <<< (VALUE_WIDTH - 1)) - 64'sd1;
  localparam logic signed [63:0] VAL_MIN  = -VAL_MAX - 64'sd1;

  typedef struct packed {
    val_t sub_diag;
    val_t main_diag;
    val_t super_diag;
    val_t rhs_value;
  } in_word_t;

  typedef struct packed {
    val_t solution;
    row_t row_index;
    logic last;
    logic pivot_error;
  } out_word_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_ROW0,
    ST_FW_RD,
    ST_FW_DIV,
    ST_FW_DIVW,
    ST_FW_MULP,
    ST_FW_MULPW,
    ST_FW_MULR,
    ST_FW_MULRW,
    ST_DECIDE,
    ST_BK_RD0,
    ST_BK_DIV0,
    ST_BK_DIVW,
    ST_BK_RD,
    ST_BK_MUL,
    ST_BK_MULW,
    ST_BK_DIV,
    ST_EM_RD,
    ST_EM_WR
  } state_t;

  typedef enum logic [1:0] {
    NUM_A,
    NUM_R,
    NUM_T
  } num_sel_t;

  typedef struct packed {
    row_t     rd_addr;
    row_t     wr_addr;
    logic     load_row;
    logic     wr_p;
    logic     wr_r;
    logic     pr_raw;
    logic     div_start;
    num_sel_t num_sel;
    logic     mul_start;
    logic     mul_upper;
    logic     cap_m;
    logic     cap_t;
    logic     wr_x;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic mul_done;
    logic out_free;
  } sts_t;

  function automatic fx_t sat48(input logic signed [63:0] v);
    if (v > WIDE_MAX) begin
      return FX_MAX;
    end
    if (v < WIDE_MIN) begin
      return FX_MIN;
    end
    return v[FX_W-1:0];
  endfunction

  function automatic fx_t widen(input val_t v);
    return sat48(64'(v) <<< PORT_SHIFT);
  endfunction

  function automatic fx_t fx_sub(input fx_t a, input fx_t b);
    return sat48(64'(a) - 64'(b));
  endfunction

  function automatic logic [FX_W-1:0] mag(input fx_t v);
    return v[FX_W-1] ? (FX_W'(0) - v) : v;
  endfunction

  function automatic val_t to_port(input fx_t x);
    logic signed [63:0] y;
    y = 64'(x >>> PORT_SHIFT);
    if (y > VAL_MAX) begin
      return VAL_MAX[VALUE_WIDTH-1:0];
    end
    if (y < VAL_MIN) begin
      return VAL_MIN[VALUE_WIDTH-1:0];
    end
    return y[VALUE_WIDTH-1:0];
  endfunction

endpackage

[rtl/tds_div.sv]
// ----------------------------------------------------------------------------
// Tridiagonal solver divider
// Restoring fixed-point divider on magnitudes, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tds_div import tds_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  fx_t  num,
  input  fx_t  den,
  output logic done,
  output fx_t  quo,
  output logic zero
);

  localparam int OV_SH = FX_W - 1 - FRAC_BITS;
  localparam int QB    = OV_SH + FRAC_BITS;
  localparam int QC_W  = $clog2(QB + 1);

  logic            busy;
  logic [QC_W-1:0] cnt;
  logic [FX_W-1:0] r;
  logic [FX_W-1:0] md;
  logic [QB-1:0]   sh;
  logic [QB-1:0]   q;
  logic            neg;

  logic [FX_W-1:0] mn_w;
  logic [FX_W-1:0] md_w;
  logic            ovf_w;
  logic [FX_W:0]   rs_w;
  logic [FX_W:0]   diff_w;
  logic            ge_w;

  assign mn_w   = mag(num);
  assign md_w   = mag(den);
  assign ovf_w  = {{OV_SH{1'b0}}, mn_w} >= {md_w, {OV_SH{1'b0}}};
  assign rs_w   = {r, sh[QB-1]};
  assign diff_w = rs_w - {1'b0, md};
  assign ge_w   = rs_w >= {1'b0, md};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        if (den == '0 || ovf_w) begin
          done <= 1'b1;
        end else begin
          busy <= 1'b1;
          cnt  <= QC_W'(QB);
        end
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg  <= num[FX_W-1] ^ den[FX_W-1];
      zero <= (den == '0);
      md   <= md_w;
      r    <= mn_w >> OV_SH;
      sh   <= {mn_w[OV_SH-1:0], {FRAC_BITS{1'b0}}};
      q    <= '0;
      if (den == '0) begin
        if (num[FX_W-1]) begin
          quo <= FX_MIN;
        end else if (num != '0) begin
          quo <= FX_MAX;
        end else begin
          quo <= '0;
        end
      end else if (ovf_w) begin
        quo <= (num[FX_W-1] ^ den[FX_W-1]) ? FX_MIN : FX_MAX;
      end
    end else if (busy) begin
      if (cnt != '0) begin
        sh <= sh << 1;
        if (ge_w) begin
          r <= diff_w[FX_W-1:0];
          q <= {q[QB-2:0], 1'b1};
        end else begin
          r <= rs_w[FX_W-1:0];
          q <= {q[QB-2:0], 1'b0};
        end
      end else begin
        quo <= neg ? -fx_t'({1'b0, q}) : fx_t'({1'b0, q});
      end
    end
  end

endmodule

[rtl/tds_mul.sv]
// ----------------------------------------------------------------------------
// Tridiagonal solver multiplier
// Fixed-point multiply from four half-width partial products over cycles.
// ----------------------------------------------------------------------------
module tds_mul import tds_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  fx_t  a,
  input  fx_t  b,
  output logic done,
  output fx_t  prod
);

  localparam int HALF  = FX_W - FRAC_BITS;
  localparam int PP_W  = 2 * HALF;
  localparam int ACC_W = FX_W + FRAC_BITS;

  logic             busy;
  logic [2:0]       cnt;
  logic [FX_W-1:0]  ma;
  logic [FX_W-1:0]  mb;
  logic             neg;
  logic [PP_W-1:0]  pp;
  logic [ACC_W-1:0] acc;
  logic [HALF-1:0]  x_w;
  logic [HALF-1:0]  y_w;

  assign x_w = (cnt == 3'd0 || cnt == 3'd1) ? ma[FX_W-1:FRAC_BITS] : HALF'(ma[FRAC_BITS-1:0]);
  assign y_w = (cnt == 3'd0 || cnt == 3'd2) ? mb[FX_W-1:FRAC_BITS] : HALF'(mb[FRAC_BITS-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == 3'd5) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ma  <= mag(a);
      mb  <= mag(b);
      neg <= a[FX_W-1] ^ b[FX_W-1];
      acc <= '0;
    end else if (busy) begin
      if (cnt < 3'd4) begin
        pp <= x_w * y_w;
      end
      unique case (cnt)
        3'd1: acc <= acc + {pp[ACC_W-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
        3'd2, 3'd3: acc <= acc + ACC_W'(pp);
        3'd4: acc <= acc + ACC_W'(pp[PP_W-1:FRAC_BITS]);
        3'd5: begin
          if (acc >= (ACC_W'(1) << (FX_W - 1))) begin
            prod <= neg ? FX_MIN : FX_MAX;
          end else begin
            prod <= neg ? -fx_t'(acc[FX_W-1:0]) : fx_t'(acc[FX_W-1:0]);
          end
        end
        default: acc <= acc;
      endcase
    end
  end

endmodule

[rtl/tds_dp.sv]
// ----------------------------------------------------------------------------
// Tridiagonal solver datapath
// Row stores, working registers, arithmetic units and the output register.
// ----------------------------------------------------------------------------
module tds_dp import tds_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  in_word_t  in_data,
  input  cmd_t      cmd,
  output sts_t      sts,
  output logic      out_valid,
  output out_word_t out_data,
  input  logic      out_stall
);

  fx_t  pmem [MAX_ROWS];
  fx_t  rmem [MAX_ROWS];
  val_t umem [MAX_ROWS];
  val_t xmem [MAX_ROWS];

  fx_t  a_r;
  fx_t  b_r;
  fx_t  f_r;
  fx_t  p_rd;
  fx_t  r_rd;
  val_t u_rd;
  val_t x_rd;
  fx_t  m_r;
  fx_t  t_r;
  logic err;

  fx_t  div_num;
  fx_t  quo;
  logic div_done;
  logic zero;
  fx_t  mul_b;
  fx_t  prod;
  logic mul_done;

  always_comb begin
    unique case (cmd.num_sel)
      NUM_A:   div_num = a_r;
      NUM_R:   div_num = r_rd;
      NUM_T:   div_num = t_r;
      default: div_num = a_r;
    endcase
  end

  assign mul_b = cmd.mul_upper ? widen(u_rd) : r_rd;

  tds_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (p_rd),
    .done  (div_done),
    .quo   (quo),
    .zero  (zero)
  );

  tds_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.mul_start),
    .a     (m_r),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (prod)
  );

  always_ff @(posedge clk) begin
    p_rd <= pmem[cmd.rd_addr];
    r_rd <= rmem[cmd.rd_addr];
    u_rd <= umem[cmd.rd_addr];
    x_rd <= xmem[cmd.rd_addr];
    if (cmd.load_row) begin
      a_r                <= widen(in_data.sub_diag);
      b_r                <= widen(in_data.main_diag);
      f_r                <= widen(in_data.rhs_value);
      umem[cmd.wr_addr]  <= in_data.super_diag;
    end
    if (cmd.wr_p) begin
      pmem[cmd.wr_addr] <= cmd.pr_raw ? b_r : fx_sub(b_r, prod);
    end
    if (cmd.wr_r) begin
      rmem[cmd.wr_addr] <= cmd.pr_raw ? f_r : fx_sub(f_r, prod);
    end
    if (cmd.wr_x) begin
      xmem[cmd.wr_addr] <= to_port(quo);
    end
    if (cmd.cap_m) begin
      m_r <= quo;
    end
    if (cmd.cap_t) begin
      t_r <= fx_sub(r_rd, prod);
    end
    if (cmd.out_load) begin
      out_data.solution    <= x_rd;
      out_data.row_index   <= cmd.rd_addr;
      out_data.last        <= (cmd.rd_addr == '0);
      out_data.pivot_error <= err;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      err       <= 1'b0;
    end else begin
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (div_done && zero) begin
        err <= 1'b1;
      end else if (cmd.out_load && cmd.rd_addr == '0) begin
        err <= 1'b0;
      end
    end
  end

  assign sts.div_done = div_done;
  assign sts.mul_done = mul_done;
  assign sts.out_free = !out_valid || !out_stall;

endmodule

[rtl/tds_ctrl.sv]
// ----------------------------------------------------------------------------
// Tridiagonal solver controller
// Sequences forward elimination, back substitution and result output.
// ----------------------------------------------------------------------------
module tds_ctrl import tds_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic cfg_we,
  input  cnt_t cfg_data,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state;
  state_t state_next;
  cnt_t   row_count;
  row_t   idx;
  row_t   bi;
  cnt_t   eff;
  logic   run_end;

  always_comb begin
    if (row_count == '0) begin
      eff = cnt_t'(1);
    end else if (row_count > cnt_t'(MAX_ROWS)) begin
      eff = cnt_t'(MAX_ROWS);
    end else begin
      eff = row_count;
    end
  end

  assign run_end  = (cnt_t'(idx) + 1'b1) >= eff;
  assign in_stall = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = (idx == '0) ? ST_ROW0 : ST_FW_RD;
        end
      end
      ST_ROW0:     state_next = ST_DECIDE;
      ST_FW_RD:    state_next = ST_FW_DIV;
      ST_FW_DIV:   state_next = ST_FW_DIVW;
      ST_FW_DIVW:  if (sts.div_done) state_next = ST_FW_MULP;
      ST_FW_MULP:  state_next = ST_FW_MULPW;
      ST_FW_MULPW: if (sts.mul_done) state_next = ST_FW_MULR;
      ST_FW_MULR:  state_next = ST_FW_MULRW;
      ST_FW_MULRW: if (sts.mul_done) state_next = ST_DECIDE;
      ST_DECIDE:   state_next = run_end ? ST_BK_RD0 : ST_IDLE;
      ST_BK_RD0:   state_next = ST_BK_DIV0;
      ST_BK_DIV0:  state_next = ST_BK_DIVW;
      ST_BK_DIVW: begin
        if (sts.div_done) begin
          state_next = (bi == '0) ? ST_EM_RD : ST_BK_RD;
        end
      end
      ST_BK_RD:    state_next = ST_BK_MUL;
      ST_BK_MUL:   state_next = ST_BK_MULW;
      ST_BK_MULW:  if (sts.mul_done) state_next = ST_BK_DIV;
      ST_BK_DIV:   state_next = ST_BK_DIVW;
      ST_EM_RD:    state_next = ST_EM_WR;
      ST_EM_WR: begin
        if (sts.out_free) begin
          state_next = (bi == '0) ? ST_IDLE : ST_EM_RD;
        end
      end
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd         = '0;
    cmd.num_sel = NUM_A;
    cmd.rd_addr = bi;
    cmd.wr_addr = idx;
    unique case (state)
      ST_IDLE:     cmd.load_row = in_valid;
      ST_ROW0: begin
        cmd.wr_p   = 1'b1;
        cmd.wr_r   = 1'b1;
        cmd.pr_raw = 1'b1;
      end
      ST_FW_RD:    cmd.rd_addr = idx - 1'b1;
      ST_FW_DIV: begin
        cmd.rd_addr   = idx - 1'b1;
        cmd.div_start = 1'b1;
      end
      ST_FW_DIVW: begin
        cmd.rd_addr = idx - 1'b1;
        cmd.cap_m   = sts.div_done;
      end
      ST_FW_MULP: begin
        cmd.rd_addr   = idx - 1'b1;
        cmd.mul_start = 1'b1;
        cmd.mul_upper = 1'b1;
      end
      ST_FW_MULPW: begin
        cmd.rd_addr = idx - 1'b1;
        cmd.wr_p    = sts.mul_done;
      end
      ST_FW_MULR: begin
        cmd.rd_addr   = idx - 1'b1;
        cmd.mul_start = 1'b1;
      end
      ST_FW_MULRW: begin
        cmd.rd_addr = idx - 1'b1;
        cmd.wr_r    = sts.mul_done;
      end
      ST_BK_DIV0: begin
        cmd.div_start = 1'b1;
        cmd.num_sel   = NUM_R;
      end
      ST_BK_DIVW: begin
        cmd.wr_addr = bi;
        cmd.cap_m   = sts.div_done;
        cmd.wr_x    = sts.div_done;
      end
      ST_BK_MUL: begin
        cmd.mul_start = 1'b1;
        cmd.mul_upper = 1'b1;
      end
      ST_BK_MULW:  cmd.cap_t = sts.mul_done;
      ST_BK_DIV: begin
        cmd.div_start = 1'b1;
        cmd.num_sel   = NUM_T;
      end
      ST_EM_WR:    cmd.out_load = sts.out_free;
      default:     cmd.wr_addr = idx;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      row_count <= cnt_t'(MAX_ROWS);
      idx       <= '0;
      bi        <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        row_count <= cfg_data;
      end
      if (state == ST_DECIDE) begin
        if (run_end) begin
          bi <= idx;
        end else begin
          idx <= idx + 1'b1;
        end
      end
      if (state == ST_BK_DIVW && sts.div_done) begin
        if (bi == '0) begin
          bi  <= idx;
          idx <= '0;
        end else begin
          bi <= bi - 1'b1;
        end
      end
      if (state == ST_EM_WR && sts.out_free && bi != '0) begin
        bi <= bi - 1'b1;
      end
    end
  end

  a_div_done_waited: assert property (@(posedge clk) disable iff (rst)
    sts.div_done |-> (state == ST_FW_DIVW || state == ST_BK_DIVW))
    else $error("Divider finished outside a divide wait state.");

  a_mul_done_waited: assert property (@(posedge clk) disable iff (rst)
    sts.mul_done |-> (state == ST_FW_MULPW || state == ST_FW_MULRW || state == ST_BK_MULW))
    else $error("Multiplier finished outside a multiply wait state.");

  a_out_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> sts.out_free)
    else $error("Output word loaded while the previous word is held.");

  a_idle_row_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (cnt_t'(idx) < eff))
    else $error("Row counter reached the row count while idle.");

endmodule

[rtl/tridiagonal_solver_core.sv]
// ----------------------------------------------------------------------------
// Tridiagonal solver core
// Each row after row 0 takes a 47-step restoring divide and two multiplies
// of partial products; row 0 is only stored. Back substitution then divides
// for the last row, then multiplies and divides for each earlier row; words
// leave one at a time, last row first. Reset is synchronous; row stores are
// not cleared, and the row count returns to the maximum.
// ----------------------------------------------------------------------------
module tridiagonal_solver_core import tds_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data,
  input  logic      cfg_we,
  input  cnt_t      cfg_data
);

  cmd_t cmd;
  sts_t sts;

  tds_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .sts      (sts),
    .cmd      (cmd)
  );

  tds_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall)
  );

endmodule
